// ===== hdl/pcgbr_pkg.sv =====
package pcgbr_pkg;

   localparam int WORD_W  = 32;
   localparam int STATE_W = 64;
   localparam int CNT_W   = $clog2(WORD_W + 1);

   localparam logic [STATE_W-1:0] PCG_MULT = 64'h5851_f42d_4c95_7f2d;
   localparam logic [STATE_W-1:0] PCG_INC  = 64'h1405_7b7e_f767_814f;

   localparam logic [1:0] ACT_RAW     = 2'd0;
   localparam logic [1:0] ACT_BOUNDED = 2'd1;
   localparam logic [1:0] ACT_FRAC    = 2'd2;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_SLO_MLO,
      MUL_SHI_MLO,
      MUL_SLO_MHI,
      MUL_WORD_RANGE
   } mul_op_type;

   typedef struct packed {
      logic       load_req;
      mul_op_type mul_op;
      logic       word_cap;
      logic       save_p0;
      logic       acc_load;
      logic       acc_add;
      logic       state_upd;
      logic       res_zero;
      logic       res_load;
      logic       out_load;
      logic       div_start;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       range_zero;
      logic       reject;
      logic       div_done;
   } status_type;

   // XSH-RR output permutation of the current state
   function automatic logic [WORD_W-1:0] xsh_rr(input logic [STATE_W-1:0] s);
      logic [STATE_W-1:0]  mix;
      logic [WORD_W-1:0]   xs;
      logic [4:0]          rot;
      logic [2*WORD_W-1:0] dbl;
      mix = s ^ (s >> 18);
      xs  = mix[58:27];
      rot = s[63:59];
      dbl = {xs, xs} >> rot;
      return dbl[WORD_W-1:0];
   endfunction

endpackage

// ===== hdl/pcgbr_req_if.sv =====
interface pcgbr_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     action;
   logic [pcgbr_pkg::WORD_W-1:0]   range_bound;

   modport source (output valid, output action, output range_bound, input ready);
   modport sink   (input valid, input action, input range_bound, output ready);
endinterface

// ===== hdl/pcgbr_rsp_if.sv =====
interface pcgbr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pcgbr_pkg::WORD_W-1:0]   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// ===== hdl/pcgbr_rem.sv =====
// Restoring remainder unit, one quotient bit per cycle.
module pcgbr_rem (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [pcgbr_pkg::WORD_W-1:0] dividend,
   input  logic [pcgbr_pkg::WORD_W-1:0] divisor,
   output logic                         done,
   output logic [pcgbr_pkg::WORD_W-1:0] remainder
);

   logic [pcgbr_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [pcgbr_pkg::WORD_W-1:0] num_ff, num_in;
   logic [pcgbr_pkg::WORD_W-1:0] rem_ff, rem_in;
   logic [pcgbr_pkg::WORD_W-1:0] div_ff, div_in;
   logic [pcgbr_pkg::WORD_W:0]   trial;

   always_comb begin
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      trial  = {rem_ff, num_ff[pcgbr_pkg::WORD_W-1]};
      if (start) begin
         cnt_in = pcgbr_pkg::CNT_W'(pcgbr_pkg::WORD_W);
         num_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         num_in = num_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = pcgbr_pkg::WORD_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[pcgbr_pkg::WORD_W-1:0];
         end
      end
   end

   assign done      = (cnt_ff == pcgbr_pkg::CNT_W'(1));
   assign remainder = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

// ===== hdl/pcgbr_dp.sv =====
module pcgbr_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  pcgbr_pkg::cmd_type            cmd,
   output pcgbr_pkg::status_type         status,
   input  logic [1:0]                    req_action,
   input  logic [pcgbr_pkg::WORD_W-1:0]  req_range_bound,
   input  logic                          csr_write,
   input  logic [pcgbr_pkg::STATE_W-1:0] csr_wdata,
   output logic [pcgbr_pkg::WORD_W-1:0]  rsp_value
);

   localparam int W = pcgbr_pkg::WORD_W;

   logic [pcgbr_pkg::STATE_W-1:0] state_ff;
   logic [1:0]                    action_ff;
   logic [W-1:0]                  range_ff;
   logic [W-1:0]                  word_ff;
   logic [2*W-1:0]                prod_ff;
   logic [2*W-1:0]                p0_ff;
   logic [W-1:0]                  acc_ff;
   logic [W-1:0]                  result_ff;
   logic [W-1:0]                  out_ff;
   logic [W-1:0]                  mul_a, mul_b;
   logic [W-1:0]                  thresh;
   logic                          div_done;

   pcgbr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (W'(0) - range_ff),
      .divisor   (range_ff),
      .done      (div_done),
      .remainder (thresh)
   );

   // shared 32x32 multiplier; the 64-bit LCG product is built from three partials
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_op)
         pcgbr_pkg::MUL_NONE: begin
         end
         pcgbr_pkg::MUL_SLO_MLO: begin
            mul_a = state_ff[W-1:0];
            mul_b = pcgbr_pkg::PCG_MULT[W-1:0];
         end
         pcgbr_pkg::MUL_SHI_MLO: begin
            mul_a = state_ff[2*W-1:W];
            mul_b = pcgbr_pkg::PCG_MULT[W-1:0];
         end
         pcgbr_pkg::MUL_SLO_MHI: begin
            mul_a = state_ff[W-1:0];
            mul_b = pcgbr_pkg::PCG_MULT[2*W-1:W];
         end
         pcgbr_pkg::MUL_WORD_RANGE: begin
            mul_a = word_ff;
            mul_b = range_ff;
         end
         default: begin
         end
      endcase
   end

   assign status.action     = action_ff;
   assign status.range_zero = (range_ff == '0);
   assign status.reject     = (prod_ff[W-1:0] < thresh);
   assign status.div_done   = div_done;
   assign rsp_value         = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (csr_write) begin
         state_ff <= csr_wdata;
      end else if (cmd.state_upd) begin
         state_ff <= {acc_ff, p0_ff[W-1:0]} + pcgbr_pkg::PCG_INC;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
      if (cmd.load_req) begin
         action_ff <= req_action;
         range_ff  <= req_range_bound;
      end
      if (cmd.word_cap) begin
         word_ff <= pcgbr_pkg::xsh_rr(state_ff);
      end
      if (cmd.save_p0) begin
         p0_ff <= prod_ff;
      end
      if (cmd.acc_load) begin
         acc_ff <= prod_ff[W-1:0];
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff[W-1:0] + p0_ff[2*W-1:W];
      end
      if (cmd.res_zero) begin
         result_ff <= '0;
      end else if (cmd.res_load) begin
         priority if (action_ff == pcgbr_pkg::ACT_BOUNDED) begin
            result_ff <= prod_ff[2*W-1:W];
         end else if (action_ff == pcgbr_pkg::ACT_FRAC) begin
            result_ff <= {9'b0, word_ff[W-1:9]};
         end else begin
            result_ff <= word_ff;
         end
      end
      if (cmd.out_load) begin
         out_ff <= result_ff;
      end
   end

endmodule

// ===== hdl/pcgbr_ctrl.sv =====
module pcgbr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  pcgbr_pkg::status_type status,
   output pcgbr_pkg::cmd_type    cmd
);

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_DEC  = 9'b000000010,
      S_DIV  = 9'b000000100,
      S_M0   = 9'b000001000,
      S_M1   = 9'b000010000,
      S_M2   = 9'b000100000,
      S_M3   = 9'b001000000,
      S_UPD  = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.mul_op = pcgbr_pkg::MUL_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DEC;
            end
         end
         S_DEC: begin
            priority if (status.action == pcgbr_pkg::ACT_BOUNDED && !status.range_zero) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else if (status.action == pcgbr_pkg::ACT_RAW ||
                         status.action == pcgbr_pkg::ACT_FRAC) begin
               state_in = S_M0;
            end else begin
               cmd.res_zero = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_M0;
            end
         end
         S_M0: begin
            cmd.mul_op   = pcgbr_pkg::MUL_SLO_MLO;
            cmd.word_cap = 1'b1;
            state_in     = S_M1;
         end
         S_M1: begin
            cmd.mul_op  = pcgbr_pkg::MUL_SHI_MLO;
            cmd.save_p0 = 1'b1;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.mul_op   = pcgbr_pkg::MUL_SLO_MHI;
            cmd.acc_load = 1'b1;
            state_in     = S_M3;
         end
         S_M3: begin
            cmd.mul_op  = pcgbr_pkg::MUL_WORD_RANGE;
            cmd.acc_add = 1'b1;
            state_in    = S_UPD;
         end
         S_UPD: begin
            cmd.state_upd = 1'b1;
            // a rejected bounded draw steps the state and draws again
            if (status.action == pcgbr_pkg::ACT_BOUNDED && status.reject) begin
               state_in = S_M0;
            end else begin
               cmd.res_load = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== hdl/pcg32_bounded_random.sv =====
// Steps from request beat to result beat: raw word and fraction pass decode, the four
// multiplier states, the state update and the output stage; a zero range or unused
// action goes from decode straight to the output stage; a bounded request first runs
// the remainder unit, then a shared-multiplier draw, repeated for each rejected draw.
// One request in flight; the next is taken once the result is in the output register.
// Synchronous reset clears control and zeroes the generator state; a seed write loads it.
module pcg32_bounded_random (
   input  logic                          clock,
   input  logic                          reset,
   pcgbr_req_if.sink                     req_chan,
   pcgbr_rsp_if.source                   rsp_chan,
   input  logic                          csr_write,
   input  logic [pcgbr_pkg::STATE_W-1:0] csr_wdata
);

   pcgbr_pkg::cmd_type    cmd;
   pcgbr_pkg::status_type status;

   pcgbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pcgbr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_chan.action),
      .req_range_bound (req_chan.range_bound),
      .csr_write       (csr_write),
      .csr_wdata       (csr_wdata),
      .rsp_value       (rsp_chan.value)
   );

endmodule
